// ===== design/kts_pkg.sv =====
// kts_pkg: shared constants, command codes and helpers for the keyed table decipher
// no dependencies; imported by keyed_table_stream_decipher_top
package kts_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W    = TABLE_AW + 1;

  localparam logic [WORD_W-1:0] SEED_MASK  = 32'h5555_5555;
  localparam logic [WORD_W-1:0] TABLE_MULT = 32'd39916801;

  typedef enum logic [1:0] {
    CMD_SEED     = 2'd0,
    CMD_PEEK     = 2'd1,
    CMD_DECIPHER = 2'd2
  } cmd_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // number of ciphertext bytes for a size code; unknown codes mean four bytes
  function automatic logic [2:0] size_bytes(input logic [1:0] size_code);
    logic [2:0] n;
    case (size_code)
      SIZE_BYTE: n = 3'd1;
      SIZE_HALF: n = 3'd2;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] size_mask(input logic [1:0] size_code);
    logic [WORD_W-1:0] m;
    case (size_code)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== design/keyed_table_stream_decipher_top.sv =====
// keyed_table_stream_decipher_top: save-file word stream decipher with a 256-entry key table
// depends on kts_pkg and kts_ram
//
// one item in, one item out. tuser carries the command (seed, peek, decipher) and the
// size code, tdata the 32-bit word. a seed item xors the word with 0x55555555 to form
// the running key, then builds the key table in the ram, one entry a cycle through a
// single rotate-and-multiply unit; no next item is taken until the build is done, and
// the seed's result is the new key. a peek returns word xor key. a decipher returns
// the low 1, 2 or 4 bytes of word xor key, then reads the table entry of each
// ciphertext byte through the ram's one registered read port (one byte a cycle) and
// xors it into the key. an unknown command returns zero and changes nothing. the result
// sits in an output register, so the next item is accepted while it waits to be taken.
// a decipher before the first seed reads table entries that were never written.
module keyed_table_stream_decipher_top
  import kts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cipher_word[31:0]
  input  logic [3:0]  s_tuser,   // command[1:0], size_code[3:2]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // plain_word[31:0]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_DECODE,
    ST_FINISH
  } state_t;

  state_t              state;
  logic [WORD_W-1:0]   running_key;
  logic [WORD_W-1:0]   build_value;
  logic [COUNT_W-1:0]  build_index;
  logic [WORD_W-1:0]   word_reg;
  logic [WORD_W-1:0]   result;
  logic [2:0]          byte_idx;
  logic [2:0]          byte_count;
  logic                read_pending;

  logic                in_accept;
  cmd_t                in_cmd;
  logic [1:0]          in_size;
  logic [WORD_W-1:0]   rotated;
  logic [WORD_W-1:0]   build_next;
  logic [WORD_W-1:0]   seed_key;
  logic                out_free;

  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [TABLE_AW-1:0] ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_cmd    = cmd_t'(s_tuser[1:0]);
  assign in_size   = s_tuser[3:2];
  assign seed_key  = s_tdata ^ SEED_MASK;

  // one table step: rotate right by one, multiply modulo 2^32
  assign rotated    = {build_value[0], build_value[WORD_W-1:1]};
  assign build_next = rotated * TABLE_MULT;

  // output register can take a new result when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  // table writes only during the build, reads walk the ciphertext bytes
  assign ram_we    = (state == ST_BUILD);
  assign ram_waddr = build_index[TABLE_AW-1:0];
  assign ram_raddr = word_reg[{byte_idx[1:0], 3'b000} +: 8];

  kts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (build_next),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_key  <= '0;
      build_value  <= '0;
      build_index  <= '0;
      byte_idx     <= '0;
      byte_count   <= '0;
      read_pending <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // output register: load a finished result, or empty once taken
      if ((state == ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            word_reg     <= s_tdata;
            byte_idx     <= '0;
            byte_count   <= size_bytes(in_size);
            read_pending <= 1'b0;
            case (in_cmd)
              CMD_SEED: begin
                running_key <= seed_key;
                build_value <= seed_key;
                build_index <= '0;
                result      <= seed_key;
                state       <= ST_BUILD;
              end
              CMD_PEEK: begin
                result <= s_tdata ^ running_key;
                state  <= ST_FINISH;
              end
              CMD_DECIPHER: begin
                result <= (s_tdata ^ running_key) & size_mask(in_size);
                state  <= ST_DECODE;
              end
              default: begin
                // unknown command: zero result, running key unchanged
                result <= '0;
                state  <= ST_FINISH;
              end
            endcase
          end
        end
        ST_BUILD: begin
          // entry build_index is written with build_next this cycle
          build_value <= build_next;
          build_index <= build_index + 1'b1;
          if (build_index == COUNT_W'(TABLE_DEPTH - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_DECODE: begin
          // issue one table read a cycle; fold in the entry read last cycle
          if (read_pending) begin
            running_key <= running_key ^ ram_rdata;
          end
          if (byte_idx != byte_count) begin
            byte_idx     <= byte_idx + 1'b1;
            read_pending <= 1'b1;
          end else begin
            read_pending <= 1'b0;
            state        <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // build index steps by exactly one while the table is being filled
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) && $past(state == ST_BUILD) |-> build_index == $past(build_index) + 1'b1)
    else $error("key table build index skipped or stalled");

  // the running key is left alone while the table is built
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) && $past(state == ST_BUILD) |-> $stable(running_key))
    else $error("running key changed during table build");

  // the byte walk never passes the number of ciphertext bytes
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECODE) |-> byte_idx <= byte_count)
    else $error("decipher byte index beyond item size");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && m_tvalid && !m_tready |=> (state == ST_FINISH))
    else $error("result left finish while output register was full");

endmodule

// ===== design/kts_ram.sv =====
// kts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module kts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
